// ===== rtl/vtsl_pkg.sv =====
// ---------------------------------------------------------------------------
// vtsl_pkg
// shared types, character codes and helpers for the value change dump lexer
// ---------------------------------------------------------------------------
package vtsl_pkg;

   // lexer modes, one-hot
   typedef enum logic [9:0] {
      MODE_TOP        = 10'b00_0000_0001,
      MODE_SKIP       = 10'b00_0000_0010,
      MODE_CMD_OPEN   = 10'b00_0000_0100,
      MODE_CMD_BODY   = 10'b00_0000_1000,
      MODE_TIME       = 10'b00_0001_0000,
      MODE_SCALAR_ID  = 10'b00_0010_0000,
      MODE_VEC_VALUE  = 10'b00_0100_0000,
      MODE_REAL_VALUE = 10'b00_1000_0000,
      MODE_AWAIT_ID   = 10'b01_0000_0000,
      MODE_VR_ID      = 10'b10_0000_0000
   } mode_type;

   // field kinds
   localparam logic [2:0] KIND_TIME         = 3'd0;
   localparam logic [2:0] KIND_SCALAR_VALUE = 3'd1;
   localparam logic [2:0] KIND_SCALAR_ID    = 3'd2;
   localparam logic [2:0] KIND_VEC_VALUE    = 3'd3;
   localparam logic [2:0] KIND_REAL_VALUE   = 3'd4;
   localparam logic [2:0] KIND_VR_ID        = 3'd5;

   // progress through the "$end" token
   localparam logic [2:0] MATCH_START = 3'd0;
   localparam logic [2:0] MATCH_DONE  = 3'd4;
   localparam logic [2:0] MATCH_FAIL  = 3'd5;

   // character codes
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_ONE    = 8'h31;
   localparam logic [7:0] CHAR_LO_X   = 8'h78;
   localparam logic [7:0] CHAR_UP_X   = 8'h58;
   localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LO_B   = 8'h62;
   localparam logic [7:0] CHAR_UP_B   = 8'h42;
   localparam logic [7:0] CHAR_LO_R   = 8'h72;
   localparam logic [7:0] CHAR_UP_R   = 8'h52;
   localparam logic [7:0] CHAR_LO_E   = 8'h65;
   localparam logic [7:0] CHAR_LO_N   = 8'h6E;
   localparam logic [7:0] CHAR_LO_D   = 8'h64;

   // lexer state
   typedef struct packed {
      mode_type   mode;
      logic [7:0] held_character;
      logic [2:0] held_kind;
      logic       held_valid;
      logic       held_first;
      logic [2:0] end_match_position;
      logic       token_started;
   } lex_state_type;

   // one result item
   typedef struct packed {
      logic       valid;
      logic [2:0] field_kind;
      logic [7:0] character;
      logic       has_char;
      logic       field_first;
      logic       field_last;
      logic       event_last;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   function automatic logic completes_event(input logic [2:0] kind);
      return (kind == KIND_TIME) || (kind == KIND_SCALAR_ID) || (kind == KIND_VR_ID);
   endfunction

   // expected character at each position of "$end"
   function automatic logic [7:0] end_word_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = CHAR_DOLLAR;
         2'd1:    c = CHAR_LO_E;
         2'd2:    c = CHAR_LO_N;
         default: c = CHAR_LO_D;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/vtsl_lexer_core.sv =====
// ---------------------------------------------------------------------------
// vtsl_lexer_core
// lexer state register and the per-byte next-state and result logic
// ---------------------------------------------------------------------------
module vtsl_lexer_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 end_of_stream,
   output vtsl_pkg::result_type result
);

   vtsl_pkg::lex_state_type state_ff;
   vtsl_pkg::lex_state_type state_in;
   logic                    ws;

   assign ws = end_of_stream || vtsl_pkg::is_space(data_byte);

   always_comb begin
      state_in = state_ff;
      result   = '0;
      case (state_ff.mode)
         vtsl_pkg::MODE_TOP: begin
            if (!ws) begin
               state_in.held_valid     = 1'b0;
               state_in.held_first     = 1'b0;
               state_in.held_character = 8'd0;
               if (data_byte == vtsl_pkg::CHAR_DOLLAR) begin
                  state_in                = state_ff;
                  state_in.mode           = vtsl_pkg::MODE_CMD_OPEN;
               end else if (data_byte == vtsl_pkg::CHAR_HASH) begin
                  state_in.mode      = vtsl_pkg::MODE_TIME;
                  state_in.held_kind = vtsl_pkg::KIND_TIME;
               end else if (data_byte == vtsl_pkg::CHAR_ZERO ||
                            data_byte == vtsl_pkg::CHAR_ONE ||
                            data_byte == vtsl_pkg::CHAR_LO_X ||
                            data_byte == vtsl_pkg::CHAR_UP_X ||
                            data_byte == vtsl_pkg::CHAR_LO_Z ||
                            data_byte == vtsl_pkg::CHAR_UP_Z) begin
                  state_in.mode      = vtsl_pkg::MODE_SCALAR_ID;
                  state_in.held_kind = vtsl_pkg::KIND_SCALAR_ID;
                  // scalar value goes out at once
                  result.valid       = 1'b1;
                  result.field_kind  = vtsl_pkg::KIND_SCALAR_VALUE;
                  result.character   = data_byte;
                  result.has_char    = 1'b1;
                  result.field_first = 1'b1;
                  result.field_last  = 1'b1;
               end else if (data_byte == vtsl_pkg::CHAR_LO_B ||
                            data_byte == vtsl_pkg::CHAR_UP_B) begin
                  state_in.mode      = vtsl_pkg::MODE_VEC_VALUE;
                  state_in.held_kind = vtsl_pkg::KIND_VEC_VALUE;
               end else if (data_byte == vtsl_pkg::CHAR_LO_R ||
                            data_byte == vtsl_pkg::CHAR_UP_R) begin
                  state_in.mode      = vtsl_pkg::MODE_REAL_VALUE;
                  state_in.held_kind = vtsl_pkg::KIND_REAL_VALUE;
               end else begin
                  state_in      = state_ff;
                  state_in.mode = vtsl_pkg::MODE_SKIP;
               end
            end
         end
         vtsl_pkg::MODE_SKIP: begin
            if (ws) begin
               state_in.mode = vtsl_pkg::MODE_TOP;
            end
         end
         vtsl_pkg::MODE_CMD_OPEN: begin
            if (end_of_stream) begin
               state_in.mode = vtsl_pkg::MODE_TOP;
            end else if (ws) begin
               state_in.mode               = vtsl_pkg::MODE_CMD_BODY;
               state_in.token_started      = 1'b0;
               state_in.end_match_position = vtsl_pkg::MATCH_START;
            end
         end
         vtsl_pkg::MODE_CMD_BODY: begin
            if (end_of_stream) begin
               state_in.mode               = vtsl_pkg::MODE_TOP;
               state_in.token_started      = 1'b0;
               state_in.end_match_position = vtsl_pkg::MATCH_START;
            end else if (ws) begin
               if (state_ff.token_started &&
                   state_ff.end_match_position == vtsl_pkg::MATCH_DONE) begin
                  state_in.mode = vtsl_pkg::MODE_TOP;
               end
               state_in.token_started      = 1'b0;
               state_in.end_match_position = vtsl_pkg::MATCH_START;
            end else begin
               state_in.token_started = 1'b1;
               if (state_ff.end_match_position < vtsl_pkg::MATCH_DONE &&
                   data_byte == vtsl_pkg::end_word_char(state_ff.end_match_position[1:0]))
               begin
                  state_in.end_match_position = state_ff.end_match_position + 3'd1;
               end else begin
                  state_in.end_match_position = vtsl_pkg::MATCH_FAIL;
               end
            end
         end
         vtsl_pkg::MODE_TIME, vtsl_pkg::MODE_SCALAR_ID, vtsl_pkg::MODE_VEC_VALUE,
         vtsl_pkg::MODE_REAL_VALUE, vtsl_pkg::MODE_VR_ID: begin
            if (ws) begin
               // field ends: flush held char or a bare marker
               result.valid       = 1'b1;
               result.field_kind  = state_ff.held_kind;
               result.character   = state_ff.held_valid ? state_ff.held_character : 8'd0;
               result.has_char    = state_ff.held_valid;
               result.field_first = state_ff.held_valid ? state_ff.held_first : 1'b1;
               result.field_last  = 1'b1;
               result.event_last  = vtsl_pkg::completes_event(state_ff.held_kind);
               if (state_ff.mode == vtsl_pkg::MODE_VEC_VALUE ||
                   state_ff.mode == vtsl_pkg::MODE_REAL_VALUE) begin
                  state_in.mode = vtsl_pkg::MODE_AWAIT_ID;
               end else begin
                  state_in.mode = vtsl_pkg::MODE_TOP;
               end
               state_in.held_valid     = 1'b0;
               state_in.held_first     = 1'b0;
               state_in.held_character = 8'd0;
            end else begin
               result.valid            = state_ff.held_valid;
               result.field_kind       = state_ff.held_kind;
               result.character        = state_ff.held_character;
               result.has_char         = 1'b1;
               result.field_first      = state_ff.held_first;
               state_in.held_first     = !state_ff.held_valid;
               state_in.held_valid     = 1'b1;
               state_in.held_character = data_byte;
            end
         end
         vtsl_pkg::MODE_AWAIT_ID: begin
            if (end_of_stream) begin
               state_in.mode      = vtsl_pkg::MODE_TOP;
               state_in.held_kind = vtsl_pkg::KIND_VR_ID;
               result.valid       = 1'b1;
               result.field_kind  = vtsl_pkg::KIND_VR_ID;
               result.field_first = 1'b1;
               result.field_last  = 1'b1;
               result.event_last  = 1'b1;
            end else if (!ws) begin
               // held_valid is clear here, so nothing goes out yet
               state_in.mode           = vtsl_pkg::MODE_VR_ID;
               state_in.held_kind      = vtsl_pkg::KIND_VR_ID;
               state_in.held_valid     = 1'b1;
               state_in.held_first     = 1'b1;
               state_in.held_character = data_byte;
            end
         end
         default: begin
            state_in.mode = vtsl_pkg::MODE_TOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode               <= vtsl_pkg::MODE_TOP;
         state_ff.held_character     <= 8'd0;
         state_ff.held_kind          <= vtsl_pkg::KIND_TIME;
         state_ff.held_valid         <= 1'b0;
         state_ff.held_first         <= 1'b0;
         state_ff.end_match_position <= vtsl_pkg::MATCH_START;
         state_ff.token_started      <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/vtsl_out_reg.sv =====
// ---------------------------------------------------------------------------
// vtsl_out_reg
// result register between the lexer and the result channel
// ---------------------------------------------------------------------------
module vtsl_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  vtsl_pkg::result_type result,
   input  logic                 rsp_stall,
   output logic                 has_room,
   output logic                 rsp_valid,
   output vtsl_pkg::result_type held
);

   logic                 valid_ff;
   logic                 valid_in;
   vtsl_pkg::result_type data_ff;

   // free when empty or drained this cycle
   assign has_room = !valid_ff || !rsp_stall;
   assign valid_in = (load && result.valid) || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign held      = data_ff;

endmodule

// ===== rtl/vcd_token_stream_lexer_unit.sv =====
// ---------------------------------------------------------------------------
// vcd_token_stream_lexer_unit
// value change dump lexer: splits dump text into time, value and id fields
// ---------------------------------------------------------------------------
// timing: a result is registered and appears on rsp_ in the cycle after the byte that causes it
// throughput: one byte per cycle while req_stall is low, set by the single lexer state register
// a byte is taken while the result register holds a transaction, as long
// as that transaction is drained in the same cycle
// reset: synchronous, active high; lexer returns to top level, no result
// ---------------------------------------------------------------------------
module vcd_token_stream_lexer_unit (
   input  logic       clock,
   input  logic       reset,
   // byte channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_stream,
   // field channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_field_kind,
   output logic [7:0] rsp_character,
   output logic       rsp_has_char,
   output logic       rsp_field_first,
   output logic       rsp_field_last,
   output logic       rsp_event_last
);

   logic                 accept;
   logic                 has_room;
   vtsl_pkg::result_type result;
   vtsl_pkg::result_type held;

   // stall only while the result register is full and not drained
   assign req_stall = !has_room;
   assign accept    = req_valid && has_room;

   // per-byte lexer: mode, held character and "$end" matcher
   vtsl_lexer_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_stream (req_end_of_stream),
      .result        (result)
   );

   // result register, loaded only when the byte yields a field item
   vtsl_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .result    (result),
      .rsp_stall (rsp_stall),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .held      (held)
   );

   // payload fan-out
   assign rsp_field_kind  = held.field_kind;
   assign rsp_character   = held.character;
   assign rsp_has_char    = held.has_char;
   assign rsp_field_first = held.field_first;
   assign rsp_field_last  = held.field_last;
   assign rsp_event_last  = held.event_last;

endmodule

// ===== rtl/vtsl_checker.sv =====
// ---------------------------------------------------------------------------
// vtsl_checker
// port-level checks for the value change dump lexer
// ---------------------------------------------------------------------------
module vtsl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_field_kind,
   input logic       rsp_has_char,
   input logic       rsp_field_first,
   input logic       rsp_field_last,
   input logic       rsp_event_last
);

   // result register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result present after reset");

   // a stalled transaction stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_field_kind)
         && $stable(rsp_event_last))
      else $error("stalled result changed");

   // a bare marker is a whole field
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_char |-> rsp_field_first && rsp_field_last)
      else $error("bare marker not first and last");

   // only the last item of a time or id field ends an event
   a_event_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_last |-> rsp_field_last &&
         (rsp_field_kind == vtsl_pkg::KIND_TIME ||
          rsp_field_kind == vtsl_pkg::KIND_SCALAR_ID ||
          rsp_field_kind == vtsl_pkg::KIND_VR_ID))
      else $error("event end on wrong field");

   // no stall while the result register is empty
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule

bind vcd_token_stream_lexer_unit vtsl_checker u_vtsl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_field_kind  (rsp_field_kind),
   .rsp_has_char    (rsp_has_char),
   .rsp_field_first (rsp_field_first),
   .rsp_field_last  (rsp_field_last),
   .rsp_event_last  (rsp_event_last)
);
